@@ sv/lfe_pkg.sv @@
// Shared types and constants for the LLDP frame field extractor.
// No dependencies; imported by every module of the block.
package lfe_pkg;

  localparam int unsigned ScanLimit = 512;
  localparam logic [9:0]  OffMax    = 10'd1023;
  localparam logic [3:0]  IdxMax    = 4'd15;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  // signature bytes and search pattern
  localparam logic [7:0]  SigByte2   = 8'h01;
  localparam logic [7:0]  SigByte3   = 8'd128;
  localparam logic [7:0]  SigByte4   = 8'd194;
  localparam logic [7:0]  SigByte7   = 8'd14;
  localparam logic [31:0] VlanPattern = 32'h0080_C201;

  localparam logic [5:0] RstTlvStart = 6'd16;
  localparam logic [2:0] RstPortOrd  = 3'd3;
  localparam logic [2:0] RstDescOrd  = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTlvStart = 2'd0,
    CfgPortOrd  = 2'd1,
    CfgDescOrd  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        text_valid;
    logic        text_tag;
    logic [7:0]  text_char;
    logic        text_end;
    logic        summary_valid;
    logic        is_lldp;
    logic        vlan_found;
    logic [15:0] vlan_id;
  } result_t;

endpackage

@@ sv/lfe_in_reg.sv @@
// Input register slice of the LLDP frame field extractor.
// Depends on lfe_pkg for the input word type.
module lfe_in_reg import lfe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_word_t word_o
);

  logic     valid_q;
  in_word_t word_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign word_o     = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= in_word_i;
    end
  end

endmodule

@@ sv/lfe_parse.sv @@
// Parsing core: configuration registers, per-buffer state and the
// combinational update for one word. Depends on lfe_pkg.
module lfe_parse import lfe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                item_valid_i,
  input  in_word_t            item_i,
  input  logic                room_i,
  output logic                take_o,
  output logic                res_valid_o,
  output result_t             res_o
);

  logic [5:0] cfg_start_q;
  logic [2:0] cfg_port_q;
  logic [2:0] cfg_desc_q;

  logic [9:0]  off_q, off_d;
  logic        lldp_q, lldp_d;
  logic [9:0]  ntlv_q, ntlv_d;
  logic [3:0]  tidx_q, tidx_d;
  logic        thi_q, thi_d;
  logic [8:0]  trem_q, trem_d;
  logic        twhich_q, twhich_d;
  logic [39:0] win_q, win_d;
  logic [8:0]  vrem_q, vrem_d;
  logic [15:0] vacc_q, vacc_d;
  logic        vseen_q, vseen_d;

  // state as seen by this word, after a possible buffer start
  logic [9:0]  off_s;
  logic        lldp_s;
  logic [9:0]  ntlv_s;
  logic [3:0]  tidx_s;
  logic        thi_s;
  logic [8:0]  trem_s;
  logic        twhich_s;
  logic [39:0] win_s;
  logic [8:0]  vrem_s;
  logic [15:0] vacc_s;
  logic        vseen_s;

  logic [7:0]  b;
  logic        in_scan;
  logic [8:0]  tlen;
  logic [10:0] nx;
  logic        tv, tend;
  logic [7:0]  plen;

  assign take_o = item_valid_i && room_i;
  assign b      = item_i.data_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_start_q <= RstTlvStart;
      cfg_port_q  <= RstPortOrd;
      cfg_desc_q  <= RstDescOrd;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTlvStart: cfg_start_q <= cfg_wdata_i;
        CfgPortOrd:  cfg_port_q  <= cfg_wdata_i[2:0];
        CfgDescOrd:  cfg_desc_q  <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (item_i.first_byte) begin
      off_s    = '0;
      lldp_s   = 1'b0;
      ntlv_s   = {4'd0, cfg_start_q};
      tidx_s   = '0;
      thi_s    = 1'b0;
      trem_s   = '0;
      twhich_s = 1'b0;
      win_s    = '0;
      vrem_s   = '0;
      vacc_s   = '0;
      vseen_s  = 1'b0;
    end else begin
      off_s    = off_q;
      lldp_s   = lldp_q;
      ntlv_s   = ntlv_q;
      tidx_s   = tidx_q;
      thi_s    = thi_q;
      trem_s   = trem_q;
      twhich_s = twhich_q;
      win_s    = win_q;
      vrem_s   = vrem_q;
      vacc_s   = vacc_q;
      vseen_s  = vseen_q;
    end
  end

  always_comb begin
    lldp_d   = lldp_s;
    ntlv_d   = ntlv_s;
    tidx_d   = tidx_s;
    thi_d    = thi_s;
    trem_d   = trem_s;
    twhich_d = twhich_s;
    win_d    = win_s;
    vrem_d   = vrem_s;
    vacc_d   = vacc_s;
    vseen_d  = vseen_s;
    tv       = 1'b0;
    tend     = 1'b0;
    in_scan  = off_s < 10'(ScanLimit);
    tlen     = {thi_s, b};
    nx       = {1'b0, ntlv_s} + 11'd2 + {2'd0, tlen};
    plen     = 8'd0;

    if (in_scan) begin
      case (off_s)
        10'd2:   lldp_d = (b == SigByte2);
        10'd3:   lldp_d = lldp_s && (b == SigByte3);
        10'd4:   lldp_d = lldp_s && (b == SigByte4);
        10'd7:   lldp_d = lldp_s && (b == SigByte7);
        default: ;
      endcase

      if (trem_s != 9'd0) begin
        tv     = 1'b1;
        tend   = (trem_s == 9'd1);
        trem_d = trem_s - 9'd1;
      end else if (off_s == ntlv_s) begin
        thi_d = b[0];
      end else if (ntlv_s < OffMax && off_s == ntlv_s + 10'd1) begin
        // type/length header complete: pick capture and jump to next tlv
        if (tidx_s == {1'b0, cfg_port_q}) begin
          trem_d   = tlen;
          twhich_d = 1'b0;
        end else if (tidx_s == {1'b0, cfg_desc_q}) begin
          trem_d   = tlen;
          twhich_d = 1'b1;
        end
        ntlv_d = (nx > {1'b0, OffMax}) ? OffMax : nx[9:0];
        if (tidx_s < IdxMax) begin
          tidx_d = tidx_s + 4'd1;
        end
      end

      if (vrem_s != 9'd0) begin
        vacc_d = {vacc_s[7:0], b};
        vrem_d = vrem_s - 9'd1;
      end

      win_d = {win_s[31:0], b};
      if (!vseen_s && off_s >= 10'd3 && win_d[31:0] == VlanPattern) begin
        plen    = win_d[39:32];
        vseen_d = 1'b1;
        vacc_d  = '0;
        vrem_d  = (plen >= 8'd4) ? {1'b0, plen - 8'd4} : 9'd0;
      end
    end

    off_d = (off_s < OffMax) ? off_s + 10'd1 : off_s;

    res_valid_o         = tv || item_i.last_byte;
    res_o.text_valid    = tv;
    res_o.text_tag      = tv ? twhich_s : 1'b0;
    res_o.text_char     = tv ? b : 8'd0;
    res_o.text_end      = tend;
    res_o.summary_valid = item_i.last_byte;
    res_o.is_lldp       = item_i.last_byte && lldp_d && (off_s >= 10'd7);
    res_o.vlan_found    = item_i.last_byte && vseen_d;
    res_o.vlan_id       = (item_i.last_byte && vseen_d) ? vacc_d : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      lldp_q   <= 1'b0;
      ntlv_q   <= {4'd0, RstTlvStart};
      tidx_q   <= '0;
      thi_q    <= 1'b0;
      trem_q   <= '0;
      twhich_q <= 1'b0;
      win_q    <= '0;
      vrem_q   <= '0;
      vacc_q   <= '0;
      vseen_q  <= 1'b0;
    end else if (take_o) begin
      if (item_i.last_byte) begin
        // next buffer starts fresh with the offset in force now
        off_q    <= '0;
        lldp_q   <= 1'b0;
        ntlv_q   <= {4'd0, cfg_start_q};
        tidx_q   <= '0;
        thi_q    <= 1'b0;
        trem_q   <= '0;
        twhich_q <= 1'b0;
        win_q    <= '0;
        vrem_q   <= '0;
        vacc_q   <= '0;
        vseen_q  <= 1'b0;
      end else begin
        off_q    <= off_d;
        lldp_q   <= lldp_d;
        ntlv_q   <= ntlv_d;
        tidx_q   <= tidx_d;
        thi_q    <= thi_d;
        trem_q   <= trem_d;
        twhich_q <= twhich_d;
        win_q    <= win_d;
        vrem_q   <= vrem_d;
        vacc_q   <= vacc_d;
        vseen_q  <= vseen_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && item_i.last_byte |=> off_q == 10'd0 && !vseen_q && trem_q == 9'd0)
    else $error("state not cleared after last word");

  a_vlan_after_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vrem_q != 9'd0 |-> vseen_q)
    else $error("vlan bytes pending without pattern match");

  a_text_after_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trem_q != 9'd0 |-> tidx_q != 4'd0)
    else $error("text capture pending before any tlv header");
`endif

endmodule

@@ sv/lfe_out_reg.sv @@
// Output register of the LLDP frame field extractor; packs the result word.
// Depends on lfe_pkg for the result type.
module lfe_out_reg import lfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic        load_valid_i,
  input  result_t     res_i,
  output logic        room_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  logic    valid_q;
  result_t res_q;

  assign room_o          = !valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {4'd0, res_q.vlan_id, res_q.vlan_found, res_q.is_lldp,
                            res_q.text_end, res_q.text_char, res_q.text_valid};
  assign m_axis_tuser_o  = res_q.text_tag;
  assign m_axis_tlast_o  = res_q.summary_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= load_valid_i;
    end else if (m_axis_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

@@ sv/lldp_frame_field_extractor_unit.sv @@
// Top level of the LLDP frame field extractor.
// Depends on lfe_pkg, lfe_in_reg, lfe_parse and lfe_out_reg.

// Takes one buffer byte per cycle unless the output stalls (2-byte length
// prefix, then the Ethernet frame), first byte flagged on tuser, final byte
// on tlast. It sustains one byte per clock while m_axis_tready holds: each
// byte goes input register -> combinational parse update -> output register,
// and its result word is held in the output register until taken. The
// per-byte state update in the parse core is combinational. A result word is
// produced for every captured TLV value byte and for every final byte (summary
// on tlast); other bytes produce nothing. A TLV start offset write takes effect
// at the next buffer start; ordinal writes apply from the next TLV header.
module lldp_frame_field_extractor_unit import lfe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // data_byte
  input  logic                s_axis_tuser_i,  // first_byte
  input  logic                s_axis_tlast_i,  // last_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // text_valid, text_char[7:0], text_end, is_lldp, vlan_found, vlan_id[15:0], zero pad
  output logic [31:0]         m_axis_tdata_o,
  output logic                m_axis_tuser_o,  // text_tag
  output logic                m_axis_tlast_o   // summary_valid
);

  in_word_t in_word, item;
  logic     item_valid, take, room, res_valid;
  result_t  res;

  assign in_word.data_byte  = s_axis_tdata_i;
  assign in_word.first_byte = s_axis_tuser_i;
  assign in_word.last_byte  = s_axis_tlast_i;

  lfe_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_word_i  (in_word),
    .take_i     (take),
    .valid_o    (item_valid),
    .word_o     (item)
  );

  lfe_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .room_i       (room),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  lfe_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (take),
    .load_valid_i    (res_valid),
    .res_i           (res),
    .room_o          (room),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

@@ bench/lldp_frame_field_extractor_unit_tb.sv @@
// Self-checking bench for lldp_frame_field_extractor_unit: random LLDP buffers,
// with a byte-level field predictor and an in-order result check.
// Depends on lfe_pkg and the extractor RTL.
module lldp_frame_field_extractor_unit_tb;
  import lfe_pkg::*;

  typedef enum int {IdleNone, IdleSource, IdleSink, IdleBoth, IdleHold} idle_mode_e;

  // tracks the parse state of the block and the result words it still owes
  class lldp_parse_tracker;
    logic [5:0]  start_ofs;
    logic [2:0]  port_ord;
    logic [2:0]  desc_ord;
    logic [9:0]  byte_ofs;
    logic        lldp_hit;
    logic [9:0]  next_tlv;
    logic [3:0]  tlv_idx;
    logic        len_msb;
    logic [8:0]  text_left;
    logic        text_sel;
    logic [39:0] window;
    logic [8:0]  vlan_left;
    logic [15:0] vlan_acc;
    logic        vlan_hit;
    result_t     due_fields[$];
    int          errors;

    function new();
      start_ofs = RstTlvStart;
      port_ord  = RstPortOrd;
      desc_ord  = RstDescOrd;
      errors    = 0;
      restart();
    endfunction

    function void restart();
      byte_ofs  = '0;
      lldp_hit  = 1'b0;
      next_tlv  = {4'd0, start_ofs};
      tlv_idx   = '0;
      len_msb   = 1'b0;
      text_left = '0;
      text_sel  = 1'b0;
      window    = '0;
      vlan_left = '0;
      vlan_acc  = '0;
      vlan_hit  = 1'b0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgTlvStart: start_ofs = val;
        CfgPortOrd:  port_ord  = val[2:0];
        CfgDescOrd:  desc_ord  = val[2:0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic first, logic last);
      logic [9:0]  o;
      logic [8:0]  len;
      logic [10:0] nx;
      result_t     r;
      r = '0;
      if (first) restart();
      o = byte_ofs;
      if (o < ScanLimit) begin
        case (o)
          10'd2: lldp_hit = (b == SigByte2);
          10'd3: lldp_hit = lldp_hit && (b == SigByte3);
          10'd4: lldp_hit = lldp_hit && (b == SigByte4);
          10'd7: lldp_hit = lldp_hit && (b == SigByte7);
          default: ;
        endcase
        if (text_left != 0) begin
          r.text_valid = 1'b1;
          r.text_tag   = text_sel;
          r.text_char  = b;
          r.text_end   = (text_left == 9'd1);
          text_left--;
        end else if (o == next_tlv) begin
          len_msb = b[0];
        end else if (next_tlv < OffMax && o == next_tlv + 10'd1) begin
          len = {len_msb, b};
          nx  = {1'b0, next_tlv} + 11'd2 + {2'b00, len};
          if (tlv_idx == {1'b0, port_ord}) begin
            text_left = len;
            text_sel  = 1'b0;
          end else if (tlv_idx == {1'b0, desc_ord}) begin
            text_left = len;
            text_sel  = 1'b1;
          end
          next_tlv = (nx > {1'b0, OffMax}) ? OffMax : nx[9:0];
          if (tlv_idx < IdxMax) tlv_idx++;
        end
        if (vlan_left != 0) begin
          vlan_acc = {vlan_acc[7:0], b};
          vlan_left--;
        end
        window = {window[31:0], b};
        if (!vlan_hit && o >= 10'd3 && window[31:0] == VlanPattern) begin
          // byte in front of the pattern is the org tlv length
          vlan_hit  = 1'b1;
          vlan_acc  = '0;
          vlan_left = (window[39:32] >= 8'd4) ? {1'b0, window[39:32] - 8'd4} : 9'd0;
        end
      end
      if (last) begin
        r.summary_valid = 1'b1;
        r.is_lldp       = lldp_hit && (o >= 10'd7);
        r.vlan_found    = vlan_hit;
        r.vlan_id       = vlan_hit ? vlan_acc : 16'd0;
      end
      if (byte_ofs < OffMax) byte_ofs++;
      if (last) restart();
      if (r.text_valid || last) due_fields.push_back(r);
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_word(logic [31:0] d, logic tag, logic summ);
      result_t want;
      if (due_fields.size() == 0) begin
        $error("unexpected result word: tdata %h tuser %b tlast %b", d, tag, summ);
        errors++;
        return;
      end
      want = due_fields.pop_front();
      cmp("text_valid", 32'(want.text_valid), 32'(d[0]));
      cmp("text_char", 32'(want.text_char), 32'(d[8:1]));
      cmp("text_end", 32'(want.text_end), 32'(d[9]));
      cmp("is_lldp", 32'(want.is_lldp), 32'(d[10]));
      cmp("vlan_found", 32'(want.vlan_found), 32'(d[11]));
      cmp("vlan_id", 32'(want.vlan_id), 32'(d[27:12]));
      cmp("pad", 32'd0, 32'(d[31:28]));
      cmp("text_tag", 32'(want.text_tag), 32'(tag));
      cmp("summary_valid", 32'(want.summary_valid), 32'(summ));
    endfunction

    function int pending();
      return due_fields.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [7:0]          s_data = '0;
  logic                s_first = 1'b0;
  logic                s_last = 1'b0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [31:0]         m_data;
  logic                m_user;
  logic                m_last;

  lldp_parse_tracker tracker = new();
  int src_pct = 0;
  int sink_pct = 0;
  bit hold_req = 1'b0;
  bit need_first = 1'b0;
  int phase_words = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lldp_frame_field_extractor_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_first),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  // receiver: checks words and drives tready, with an optional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_valid && m_ready) tracker.match_word(m_data, m_user, m_last);
      if (hold_req) begin
        hold_left = 300;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= sink_pct);
      end
    end
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic push_byte(logic [7:0] d, logic f, logic l);
    f = f | need_first;
    need_first = 1'b0;
    while (src_pct != 0 && $urandom_range(99) < src_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= d;
    s_first <= f;
    s_last  <= l;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    tracker.take_byte(d, f, l);
    phase_words++;
  endtask

  // sends n bytes of v, most significant first, as one buffer
  task automatic send_hex(logic [63:0] v, int n, logic first);
    int i;
    for (i = 0; i < n; i++) begin
      push_byte(v[8*(n-1-i) +: 8], first && i == 0, i == n - 1);
    end
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [5:0] st, logic [2:0] po, logic [2:0] de);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgTlvStart;
    cfg_data <= st;
    @(posedge clk_i);
    tracker.set_reg(CfgTlvStart, st);
    cfg_idx  <= CfgPortOrd;
    cfg_data <= {3'd0, po};
    @(posedge clk_i);
    tracker.set_reg(CfgPortOrd, {3'd0, po});
    cfg_idx  <= CfgDescOrd;
    cfg_data <= {3'd0, de};
    @(posedge clk_i);
    tracker.set_reg(CfgDescOrd, {3'd0, de});
    cfg_we <= 1'b0;
    // the new start offset takes effect at a buffer start, so flag the next byte first
    need_first = 1'b1;
  endtask

  task automatic send_frame();
    logic [7:0] frame_q[$];
    int kind, n_tlv, vlan_at, tlv_len, r, t, i, cut;
    bit noisy;
    kind  = $urandom_range(99);
    noisy = (kind < 12);
    if (noisy) begin
      repeat ($urandom_range(48, 1)) frame_q.push_back(8'($urandom));
    end else begin
      repeat (2) frame_q.push_back(8'($urandom));
      frame_q.push_back(SigByte2);
      frame_q.push_back(SigByte3);
      frame_q.push_back(SigByte4);
      frame_q.push_back(8'h00);
      frame_q.push_back(8'h00);
      frame_q.push_back(SigByte7);
      repeat (6) frame_q.push_back(8'($urandom));
      frame_q.push_back(8'h88);
      frame_q.push_back(8'hCC);
      if (kind < 27) begin
        case ($urandom_range(3))
          0: frame_q[2] = 8'($urandom);
          1: frame_q[3] = 8'($urandom);
          2: frame_q[4] = 8'($urandom);
          default: frame_q[7] = 8'($urandom);
        endcase
      end
      while (frame_q.size() > tracker.start_ofs) void'(frame_q.pop_back());
      while (frame_q.size() < tracker.start_ofs) frame_q.push_back(8'($urandom));
      n_tlv   = ($urandom_range(3) == 0) ? $urandom_range(20, 14) : $urandom_range(8);
      vlan_at = ($urandom_range(9) < 7) ? $urandom_range(n_tlv) : -1;
      for (t = 0; t <= n_tlv; t++) begin
        if (t == vlan_at) begin
          // organizational tlv carrying the vlan pattern
          tlv_len = ($urandom_range(9) < 6) ? 6 : $urandom_range(12);
          frame_q.push_back({7'd127, 1'b0});
          frame_q.push_back(8'(tlv_len));
          frame_q.push_back(VlanPattern[31:24]);
          frame_q.push_back(VlanPattern[23:16]);
          frame_q.push_back(VlanPattern[15:8]);
          frame_q.push_back(VlanPattern[7:0]);
          repeat ((tlv_len > 4) ? tlv_len - 4 : 0) frame_q.push_back(8'($urandom));
        end else if (t < n_tlv) begin
          r = $urandom_range(999);
          if (r < 850) tlv_len = $urandom_range(8);
          else if (r < 985) tlv_len = $urandom_range(40, 9);
          else if (r < 998) tlv_len = $urandom_range(200, 41);
          else tlv_len = $urandom_range(511, 201);
          frame_q.push_back({7'($urandom), tlv_len[8]});
          frame_q.push_back(tlv_len[7:0]);
          repeat (tlv_len) frame_q.push_back(8'($urandom));
        end
      end
      if ($urandom_range(1) == 0) begin
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
      end
      if (kind < 22 && frame_q.size() > 0) begin
        cut = $urandom_range(frame_q.size(), 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
      if (frame_q.size() == 0) frame_q.push_back(8'($urandom));
    end
    for (i = 0; i < frame_q.size(); i++) begin
      push_byte(frame_q[i],
                (i == 0) ? ($urandom_range(9) != 0) : (noisy && $urandom_range(31) == 0),
                (i == frame_q.size() - 1) || (noisy && $urandom_range(31) == 0));
    end
  endtask

  // buffer past the scan limit and past the offset ceiling
  task automatic send_long();
    int i;
    logic [7:0] b;
    for (i = 0; i < 1040; i++) begin
      case (i)
        2:   b = SigByte2;
        3:   b = SigByte3;
        4:   b = SigByte4;
        7:   b = SigByte7;
        600: b = 8'd6;
        601: b = VlanPattern[31:24];
        602: b = VlanPattern[23:16];
        603: b = VlanPattern[15:8];
        604: b = VlanPattern[7:0];
        default: b = 8'($urandom);
      endcase
      push_byte(b, i == 0, i == 1039);
    end
  endtask

  task automatic run_phase(idle_mode_e mode, bit do_write, logic [5:0] st, logic [2:0] po,
                           logic [2:0] de, bit with_long, int quota);
    bit paused;
    paused = 1'b0;
    drain();
    if (do_write) write_regs(st, po, de);
    case (mode)
      IdleSource: begin src_pct = 85; sink_pct = 0; end
      IdleSink:   begin src_pct = 0; sink_pct = 85; end
      IdleBoth:   begin src_pct = 30; sink_pct = 30; end
      default:    begin src_pct = 0; sink_pct = 0; end
    endcase
    phase_words = 0;
    if (mode == IdleHold) begin
      hold_req = 1'b1;
      // two short buffers: the first summary fills the output, the rest backs up
      send_hex(64'h0000_0180_C200_000E, 8, 1'b1);
      send_hex(64'h0000_0180_C200_000E, 8, 1'b1);
    end
    if (with_long) send_long();
    while (phase_words < quota) begin
      send_frame();
      if (!paused && phase_words >= quota / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed buffers at reset settings
    send_hex(64'hFF, 1, 1'b1);
    send_hex(64'h0000_0180_C200_000E, 8, 1'b1);
    send_hex(64'h00_0080_C201_FF, 5, 1'b1);
    send_hex(64'h03_0080_C201_34, 6, 1'b1);
    send_hex(64'hAA_5501_80C2, 5, 1'b0);
    run_phase(IdleNone,   1'b0, 6'd16, 3'd3, 3'd4, 1'b0, 30);
    run_phase(IdleSource, 1'b1, 6'd0,  3'd0, 3'd0, 1'b0, 30);
    run_phase(IdleSink,   1'b1, 6'd63, 3'd7, 3'd7, 1'b0, 30);
    run_phase(IdleBoth,   1'b1, 6'd40, 3'd1, 3'd6, 1'b0, 30);
    run_phase(IdleHold,   1'b1, 6'd20, 3'd5, 3'd5, 1'b0, 30);
    run_phase(IdleNone,   1'b1, 6'd16, 3'd3, 3'd4, 1'b1, 30);
    drain();
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ lldp_frame_field_extractor_unit.f @@
sv/lfe_pkg.sv
sv/lfe_in_reg.sv
sv/lfe_parse.sv
sv/lfe_out_reg.sv
sv/lldp_frame_field_extractor_unit.sv
bench/lldp_frame_field_extractor_unit_tb.sv
